>>> sv/rawf_pkg.sv
// Shared types and constants for the register ALU with flags.
package rawf_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned REG_N  = 8;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_MOV = 2'd0,
        MODE_ADD = 2'd1,
        MODE_SUB = 2'd2,
        MODE_CMP = 2'd3
    } t_mode;

    typedef struct packed {
        logic write_back;
        logic set_flags;
        logic subtract;
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [IDX_W-1:0]         dest_index;
        logic                     use_register;
        logic [IDX_W-1:0]         source_index;
        logic signed [DATA_W-1:0] immediate_value;
    } t_entry;

    typedef struct packed {
        logic overflow_flag;
        logic sign_flag;
        logic zero_flag;
        logic adjust_flag;
        logic parity_flag;
        logic carry_flag;
    } t_flags;

endpackage

>>> sv/rawf_if.sv
// Handshake interfaces for the operation and result channels.
interface rawf_in_if;
    import rawf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         dest_index;
    logic                     use_register;
    logic [IDX_W-1:0]         source_index;
    logic signed [DATA_W-1:0] immediate_value;

    modport source (
        output valid, mode, dest_index, use_register, source_index, immediate_value,
        input  ready
    );
    modport sink (
        input  valid, mode, dest_index, use_register, source_index, immediate_value,
        output ready
    );
endinterface

interface rawf_out_if;
    import rawf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     zero_flag;
    logic                     sign_flag;
    logic                     overflow_flag;
    logic                     parity_flag;
    logic                     carry_flag;
    logic                     adjust_flag;

    modport source (
        output valid, result_value, zero_flag, sign_flag, overflow_flag,
               parity_flag, carry_flag, adjust_flag,
        input  ready
    );
    modport sink (
        input  valid, result_value, zero_flag, sign_flag, overflow_flag,
               parity_flag, carry_flag, adjust_flag,
        output ready
    );
endinterface

>>> sv/rawf_front.sv
// Front end: accept operations and classify them into control bits.
module rawf_front (
    rawf_in_if.sink           i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output rawf_pkg::t_entry  o_entry
);
    import rawf_pkg::*;

    t_op op;

    always_comb begin
        unique case (t_mode'(i_in.mode))
            MODE_MOV: op = '{write_back: 1'b1, set_flags: 1'b0, subtract: 1'b0};
            MODE_ADD: op = '{write_back: 1'b1, set_flags: 1'b1, subtract: 1'b0};
            MODE_SUB: op = '{write_back: 1'b1, set_flags: 1'b1, subtract: 1'b1};
            MODE_CMP: op = '{write_back: 1'b0, set_flags: 1'b1, subtract: 1'b1};
            default:  op = '{write_back: 1'b0, set_flags: 1'b0, subtract: 1'b0};
        endcase
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        o_entry.op              = op;
        o_entry.dest_index      = i_in.dest_index;
        o_entry.use_register    = i_in.use_register;
        o_entry.source_index    = i_in.source_index;
        o_entry.immediate_value = i_in.immediate_value;
    end

endmodule

>>> sv/rawf_queue.sv
// Small FIFO between the front end and the execute back end.
module rawf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rawf_pkg::t_entry  i_entry,
    output logic              o_ready,
    output logic              o_valid,
    output rawf_pkg::t_entry  o_entry,
    input  logic              i_pop
);
    import rawf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)) || pop)
        else $error("push into full queue");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0))
        else $error("queue not empty after reset");
`endif

endmodule

>>> sv/rawf_back.sv
// Back end: register file read, ALU with flags, write back and result register.
module rawf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  rawf_pkg::t_entry  i_q_entry,
    output logic              o_pop,
    rawf_out_if.source        o_out
);
    import rawf_pkg::*;

    logic [DATA_W-1:0]  r_mem [REG_N];
    logic [REG_N-1:0]   r_reg_vld;

    logic               r_e1_valid;
    t_entry             r_e1;
    logic [DATA_W-1:0]  r_rd_a, r_rd_b;
    logic               r_rd_a_ok, r_rd_b_ok;

    logic               r_fwd_valid;
    logic [IDX_W-1:0]   r_fwd_dst;
    logic [DATA_W-1:0]  r_fwd_val;

    t_flags             r_flags;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_result;
    t_flags             r_out_flags;

    logic               adv;
    logic               mem_we;
    logic [DATA_W-1:0]  opnd_a, opnd_src, opnd_b, addend, result;
    logic [DATA_W:0]    sum;
    logic               carry_out;
    t_flags             n_flags;

    assign adv    = !r_out_valid || o_out.ready;
    assign o_pop  = adv && i_q_valid;
    assign mem_we = adv && r_e1_valid && r_e1.op.write_back;

    always_comb begin
        if (r_fwd_valid && r_fwd_dst == r_e1.dest_index) begin
            opnd_a = r_fwd_val;
        end else begin
            opnd_a = r_rd_a_ok ? r_rd_a : '0;
        end
        if (r_fwd_valid && r_fwd_dst == r_e1.source_index) begin
            opnd_src = r_fwd_val;
        end else begin
            opnd_src = r_rd_b_ok ? r_rd_b : '0;
        end
        opnd_b = r_e1.use_register ? opnd_src : DATA_W'(r_e1.immediate_value);
    end

    always_comb begin
        addend    = r_e1.op.subtract ? ~opnd_b : opnd_b;
        sum       = {1'b0, opnd_a} + {1'b0, addend} + {{DATA_W{1'b0}}, r_e1.op.subtract};
        carry_out = sum[DATA_W];
        result    = r_e1.op.set_flags ? sum[DATA_W-1:0] : opnd_b;

        n_flags.carry_flag     = r_e1.op.subtract ? !carry_out : carry_out;
        n_flags.parity_flag    = ~^result[7:0];
        n_flags.adjust_flag    = opnd_a[4] ^ opnd_b[4] ^ result[4];
        n_flags.zero_flag      = (result == '0);
        n_flags.sign_flag      = result[DATA_W-1];
        if (r_e1.op.subtract) begin
            n_flags.overflow_flag = (opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1])
                                  & (opnd_a[DATA_W-1] ^ result[DATA_W-1]);
        end else begin
            n_flags.overflow_flag = ~(opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1])
                                  & (opnd_a[DATA_W-1] ^ result[DATA_W-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_e1.dest_index] <= result;
        end
        if (o_pop) begin
            r_rd_a <= r_mem[i_q_entry.dest_index];
            r_rd_b <= r_mem[i_q_entry.source_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld   <= '0;
            r_rd_a_ok   <= 1'b0;
            r_rd_b_ok   <= 1'b0;
            r_e1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_e1_valid  <= i_q_valid;
            r_out_valid <= r_e1_valid;
            if (i_q_valid) begin
                r_rd_a_ok <= r_reg_vld[i_q_entry.dest_index];
                r_rd_b_ok <= r_reg_vld[i_q_entry.source_index];
            end
            if (mem_we) begin
                r_reg_vld[r_e1.dest_index] <= 1'b1;
                r_fwd_valid                <= 1'b1;
            end
            if (r_e1_valid && r_e1.op.set_flags) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (i_q_valid) begin
                r_e1 <= i_q_entry;
            end
            if (mem_we) begin
                r_fwd_dst <= r_e1.dest_index;
                r_fwd_val <= result;
            end
            if (r_e1_valid) begin
                r_out_result <= result;
                r_out_flags  <= r_e1.op.set_flags ? n_flags : r_flags;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_out_result;
    assign o_out.zero_flag      = r_out_flags.zero_flag;
    assign o_out.sign_flag      = r_out_flags.sign_flag;
    assign o_out.overflow_flag  = r_out_flags.overflow_flag;
    assign o_out.parity_flag    = r_out_flags.parity_flag;
    assign o_out.carry_flag     = r_out_flags.carry_flag;
    assign o_out.adjust_flag    = r_out_flags.adjust_flag;

`ifndef SYNTHESIS
    a_cmp_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_e1.op.write_back && r_e1_valid)
        else $error("register write without a writing operation");
    a_move_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_e1_valid && !r_e1.op.set_flags |=> $stable(r_flags))
        else $error("flags changed by move");
    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_e1_valid |=> r_out_valid)
        else $error("executed operation lost before result register");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_e1_valid) && $stable(r_flags))
        else $error("execute stage moved during stall");
`endif

endmodule

>>> sv/register_alu_with_flags.sv
// Top level of the 16-bit register ALU with 8086-style flags.
//
//   channel   dir   modport  payload
//   i_in      in    sink     mode, dest_index, use_register, source_index, immediate_value
//   o_out     out   source   result_value, zero/sign/overflow/parity/carry/adjust flags
//
// One operation per cycle sustained while o_out is not stalled; an accepted operation
// is read out of the queue with its operands, then executed into the result register.
// The register file read is registered; a one-entry bypass covers the write
// issued on the same edge. Reset clears the queue, flags and register valid bits.
// A stalled result register holds the execute stage; the queue keeps accepting
// until it is full.
module register_alu_with_flags #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rawf_in_if.sink     i_in,
    rawf_out_if.source  o_out
);
    import rawf_pkg::*;

    logic   push, q_ready, q_valid, pop;
    t_entry push_entry, q_entry;

    rawf_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    rawf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    rawf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

>>> bench/tb_register_alu_with_flags.sv
// Testbench for register_alu_with_flags: random and directed ALU transactions, checked in order.
module tb_register_alu_with_flags;
    import rawf_pkg::*;

    localparam logic [IDX_W-1:0] REG_AX = 3'd0;
    localparam logic [IDX_W-1:0] REG_CX = 3'd1;
    localparam logic [IDX_W-1:0] REG_DX = 3'd2;
    localparam logic [IDX_W-1:0] REG_BX = 3'd3;
    localparam logic [IDX_W-1:0] REG_SP = 3'd4;
    localparam logic [IDX_W-1:0] REG_BP = 3'd5;
    localparam logic [IDX_W-1:0] REG_SI = 3'd6;
    localparam logic [IDX_W-1:0] REG_DI = 3'd7;

    localparam int unsigned RANDOM_OPS  = 1150;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef struct {
        t_mode              mode;
        logic [IDX_W-1:0]   dest_index;
        logic               use_register;
        logic [IDX_W-1:0]   source_index;
        logic [DATA_W-1:0]  immediate_value;
    } t_alu_op;

    typedef struct {
        logic [DATA_W-1:0] value;
        t_flags            flags;
    } t_alu_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rawf_in_if  op_bus ();
    rawf_out_if res_bus ();

    register_alu_with_flags u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_bus),
        .o_out   (res_bus)
    );

    logic [DATA_W-1:0] shadow_regs [REG_N];
    t_flags            shadow_flags;

    t_alu_op     pending_ops [$];
    t_alu_result pending_results [$];

    logic        op_took = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    logic [15:0] ready_mask = '1;

    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned ops_sent = 0;
    int unsigned mode_count [4] = '{0, 0, 0, 0};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_alu_result alu_execute(t_alu_op op);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W:0]   sum;
        t_alu_result       res;
        a = shadow_regs[op.dest_index];
        b = op.use_register ? shadow_regs[op.source_index] : op.immediate_value;
        if (op.mode == MODE_MOV) begin
            res.value = b;
            shadow_regs[op.dest_index] = b;
        end else begin
            if (op.mode == MODE_ADD) begin
                sum = {1'b0, a} + {1'b0, b};
                res.value = sum[DATA_W-1:0];
                shadow_flags.carry_flag = sum[DATA_W];
                shadow_flags.overflow_flag = ~(a[15] ^ b[15]) & (a[15] ^ res.value[15]);
            end else begin
                res.value = a - b;
                shadow_flags.carry_flag = (a < b);
                shadow_flags.overflow_flag = (a[15] ^ b[15]) & (a[15] ^ res.value[15]);
            end
            shadow_flags.parity_flag = ~^res.value[7:0];
            shadow_flags.adjust_flag = a[4] ^ b[4] ^ res.value[4];
            shadow_flags.zero_flag = (res.value == '0);
            shadow_flags.sign_flag = res.value[15];
            if (op.mode != MODE_CMP) begin
                shadow_regs[op.dest_index] = res.value;
            end
        end
        res.flags = shadow_flags;
        return res;
    endfunction

    // operand is the source register index when ur is set, else the immediate
    function automatic t_alu_op make_op(t_mode m, logic [IDX_W-1:0] d, logic ur,
                                        logic [DATA_W-1:0] operand);
        t_alu_op op;
        op.mode = m;
        op.dest_index = d;
        op.use_register = ur;
        op.source_index = ur ? operand[IDX_W-1:0] : IDX_W'($urandom);
        op.immediate_value = ur ? DATA_W'($urandom) : operand;
        return op;
    endfunction

    function automatic logic [DATA_W-1:0] pick_immediate();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'h7FFF;
                    3: v = 16'h8000;
                    default: v = 16'hFFFF;
                endcase
            end
            1: v = DATA_W'($urandom_range(0, 31));
            2: v = -DATA_W'($urandom_range(1, 32));
            default: v = DATA_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at result %0d: %s", results_checked, msg);
        end
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    task automatic check_flag(string name, logic got, logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
        end
    endtask

    // drive next transaction once the current one is taken; idle between bursts
    always @(negedge i_clk) begin
        t_alu_op nxt;
        if (i_rst_n && (!op_bus.valid || op_took)) begin
            if (gap_left != 0) begin
                gap_left--;
                op_bus.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                nxt = pending_ops.pop_front();
                op_bus.mode <= nxt.mode;
                op_bus.dest_index <= nxt.dest_index;
                op_bus.use_register <= nxt.use_register;
                op_bus.source_index <= nxt.source_index;
                op_bus.immediate_value <= nxt.immediate_value;
                op_bus.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                op_bus.valid <= 1'b0;
            end
        end
    end

    // stall the result channel on a rotating mask, reloaded now and then
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: ready_mask = '1;
                1: ready_mask = 16'($urandom & $urandom) | 16'h0001;
                default: ready_mask = 16'($urandom) | 16'h0001;
            endcase
        end else begin
            stall_left--;
        end
        res_bus.ready <= ready_mask[stall_left[3:0]];
    end

    always @(posedge i_clk) begin
        t_alu_op     op;
        t_alu_result want;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", res_bus.result_value));
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_value", res_bus.result_value, want.value);
                    check_flag("zero_flag", res_bus.zero_flag, want.flags.zero_flag);
                    check_flag("sign_flag", res_bus.sign_flag, want.flags.sign_flag);
                    check_flag("overflow_flag", res_bus.overflow_flag,
                               want.flags.overflow_flag);
                    check_flag("parity_flag", res_bus.parity_flag, want.flags.parity_flag);
                    check_flag("carry_flag", res_bus.carry_flag, want.flags.carry_flag);
                    check_flag("adjust_flag", res_bus.adjust_flag,
                               want.flags.adjust_flag);
                end
                results_checked++;
            end
            op_took <= op_bus.valid && op_bus.ready;
            if (op_bus.valid && op_bus.ready) begin
                op.mode = t_mode'(op_bus.mode);
                op.dest_index = op_bus.dest_index;
                op.use_register = op_bus.use_register;
                op.source_index = op_bus.source_index;
                op.immediate_value = op_bus.immediate_value;
                pending_results.push_back(alu_execute(op));
                mode_count[op.mode]++;
                ops_sent++;
            end
        end
    end

    initial begin
        #3_200_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        op_bus.valid = 1'b0;
        op_bus.mode = MODE_MOV;
        op_bus.dest_index = '0;
        op_bus.use_register = 1'b0;
        op_bus.source_index = '0;
        op_bus.immediate_value = '0;
        res_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        for (int i = 0; i < REG_N; i++) begin
            shadow_regs[i] = '0;
        end
        shadow_flags = '0;

        pending_ops.push_back(make_op(MODE_CMP, REG_SI, 1'b0, 16'h0000));
        pending_ops.push_back(make_op(MODE_MOV, REG_AX, 1'b0, 16'h7FFF));
        pending_ops.push_back(make_op(MODE_MOV, REG_CX, 1'b0, 16'h8000));
        pending_ops.push_back(make_op(MODE_MOV, REG_DX, 1'b0, 16'hFFFF));
        pending_ops.push_back(make_op(MODE_MOV, REG_BX, 1'b0, 16'h000F));
        pending_ops.push_back(make_op(MODE_MOV, REG_SP, 1'b1, DATA_W'(REG_BX)));
        pending_ops.push_back(make_op(MODE_ADD, REG_AX, 1'b0, 16'h0001));
        pending_ops.push_back(make_op(MODE_ADD, REG_DX, 1'b0, 16'h0001));
        pending_ops.push_back(make_op(MODE_ADD, REG_BX, 1'b1, DATA_W'(REG_SP)));
        pending_ops.push_back(make_op(MODE_ADD, REG_CX, 1'b1, DATA_W'(REG_CX)));
        pending_ops.push_back(make_op(MODE_SUB, REG_BP, 1'b0, 16'h0001));
        pending_ops.push_back(make_op(MODE_SUB, REG_AX, 1'b0, 16'h0001));
        pending_ops.push_back(make_op(MODE_CMP, REG_DI, 1'b1, DATA_W'(REG_DI)));
        pending_ops.push_back(make_op(MODE_MOV, REG_DI, 1'b0, 16'h1234));
        pending_ops.push_back(make_op(MODE_CMP, REG_DI, 1'b0, 16'h8000));
        pending_ops.push_back(make_op(MODE_ADD, REG_DI, 1'b0, 16'h8000));
        pending_ops.push_back(make_op(MODE_SUB, REG_SI, 1'b1, DATA_W'(REG_SI)));
        pending_ops.push_back(make_op(MODE_MOV, REG_BP, 1'b1, DATA_W'(REG_BP)));
        pending_ops.push_back(make_op(MODE_SUB, REG_AX, 1'b1, DATA_W'(REG_CX)));
        pending_ops.push_back(make_op(MODE_ADD, REG_SI, 1'b0, 16'hFFFF));
        pending_ops.push_back(make_op(MODE_CMP, REG_CX, 1'b1, DATA_W'(REG_BP)));
        pending_ops.push_back(make_op(MODE_SUB, REG_DX, 1'b0, 16'h7FFF));
        pending_ops.push_back(make_op(MODE_ADD, REG_BP, 1'b0, 16'h8000));
        for (int i = 0; i < RANDOM_OPS; i++) begin
            pending_ops.push_back(make_op(t_mode'($urandom_range(0, 3)),
                                          IDX_W'($urandom), 1'($urandom),
                                          pick_immediate()));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_ops.size() != 0 || op_bus.valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("sent %0d operations: %0d mov, %0d add, %0d sub, %0d cmp",
                 ops_sent, mode_count[MODE_MOV], mode_count[MODE_ADD],
                 mode_count[MODE_SUB], mode_count[MODE_CMP]);
        $display("checked %0d results under random input gaps and output stalls, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
